@@ rtl/assert_macros.svh @@
// Assertion helpers; every use samples on clk and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lse_pkg.sv @@
package lse_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int LEN_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [LEN_W-1:0]            len_t;
    typedef logic [IDX_W-1:0]            idx_t;

    // Action codes
    typedef enum logic [3:0] {
        ACT_APPEND  = 4'd0,
        ACT_INSERT  = 4'd1,
        ACT_POP     = 4'd2,
        ACT_REMOVE  = 4'd3,
        ACT_COUNT   = 4'd4,
        ACT_FIND    = 4'd5,
        ACT_REVERSE = 4'd6,
        ACT_SORT    = 4'd7,
        ACT_CLEAR   = 4'd8,
        ACT_DUMP    = 4'd9
    } action_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0]         action;
        logic [6:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } rsp_t;

    // Per-cycle command broadcast along the cell row
    typedef enum logic [2:0] {
        CK_HOLD   = 3'd0,
        CK_WRITE  = 3'd1,
        CK_INSERT = 3'd2,
        CK_POP    = 3'd3,
        CK_ROT    = 3'd4,
        CK_SORT   = 3'd5
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t kind;
        len_t       tgt;
        len_t       len;
        logic       phase;
        word_t      val;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1
    } state_t;

    // Sign-adjust a stored word to the 32-bit result field
    function automatic logic [31:0] word_to_data(word_t w);
        logic signed [63:0] x;
        x = 64'(w);
        return x[31:0];
    endfunction

    // Sign-adjust the 32-bit request value to a stored word
    function automatic word_t data_to_word(logic signed [31:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        return x[WORD_BITS-1:0];
    endfunction

endpackage

@@ rtl/lse_cell.sv @@
module lse_cell (
    input  logic              clk,
    input  lse_pkg::idx_t     idx,
    input  lse_pkg::cell_cmd_t cmd,
    input  lse_pkg::word_t    left,
    input  lse_pkg::word_t    right,
    input  lse_pkg::word_t    head,
    output lse_pkg::word_t    q
);
    import lse_pkg::*;

    word_t data_reg;
    word_t data_next;
    len_t  pos;
    len_t  pos1;

    assign pos  = LEN_W'(idx);
    assign pos1 = pos + len_t'(1);
    assign q    = data_reg;

    // Pick the next word from the broadcast command and the neighbors
    always_comb
    begin
        data_next = data_reg;
        case (cmd.kind)
            CK_WRITE:
            begin
                if (pos == cmd.tgt)
                    data_next = cmd.val;
            end
            CK_INSERT:
            begin
                if (pos == cmd.tgt)
                    data_next = cmd.val;
                else if (pos > cmd.tgt)
                    data_next = left;
            end
            CK_POP:
            begin
                if (pos >= cmd.tgt)
                    data_next = right;
            end
            CK_ROT:
            begin
                if (pos1 == cmd.tgt)
                    data_next = head;
                else if (pos1 < cmd.tgt)
                    data_next = right;
            end
            CK_SORT:
            begin
                if (idx[0] == cmd.phase && pos1 < cmd.len)
                begin
                    if (right < data_reg)
                        data_next = right;
                end
                else if (idx[0] != cmd.phase && idx != '0 && pos < cmd.len)
                begin
                    if (data_reg < left)
                        data_next = left;
                end
            end
            default:
                data_next = data_reg;
        endcase
    end

    // Hold the word; payload needs no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ rtl/list_store_engine.sv @@
// Channel  Dir  Payload  Handshake
// req      in   req_t    req_valid / req_ready
// rsp      out  rsp_t    rsp_valid / rsp_ready
//
// Append, insert, pop, clear and unknown actions finish without leaving idle.
// Remove, count, find, reverse and dump rotate the list once through the
// cell row, one element per cycle; sort runs length odd-even phases over
// the row. Dump and every final result stall while the output register is
// full. Reset clears the length; the cells keep their data.
`include "assert_macros.svh"

module list_store_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lse_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lse_pkg::rsp_t rsp
);
    import lse_pkg::*;

    state_t     state_reg, state_next;
    len_t       len_reg, len_next;
    len_t       cnt_reg, cnt_next;
    len_t       step_reg, step_next;
    len_t       acc_reg, acc_next;
    len_t       fidx_reg, fidx_next;
    logic       found_reg, found_next;
    logic       phase_reg, phase_next;
    action_t    op_reg, op_next;
    word_t      val_reg, val_next;
    logic       out_valid_reg, out_valid_next;
    rsp_t       out_reg, out_next;
    cell_cmd_t  cmd;
    word_t      cell_q [DEPTH];
    word_t      head;
    logic       slot_free;
    logic       accept;
    logic       step_ok;
    logic       match;
    word_t      req_word;
    logic [31:0] pos_ext;
    logic [31:0] len_ext;

    assign head      = cell_q[0];
    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign req_word  = data_to_word(req.value);
    assign match     = (head == val_reg);
    assign pos_ext   = 32'(req.position);
    assign len_ext   = 32'(len_reg);
    assign step_ok   = slot_free || (op_reg != ACT_DUMP && cnt_reg != len_t'(1));

    // Row of cells, each passing its word to its neighbors
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        word_t l_in, r_in;
        if (g == 0)
        begin : g_first
            assign l_in = '0;
        end
        else
        begin : g_mid_l
            assign l_in = cell_q[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_lastc
            assign r_in = '0;
        end
        else
        begin : g_mid_r
            assign r_in = cell_q[g+1];
        end
        lse_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(g)),
            .cmd   (cmd),
            .left  (l_in),
            .right (r_in),
            .head  (head),
            .q     (cell_q[g])
        );
    end

    // Sequence actions and drive the cell command
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        fidx_next      = fidx_reg;
        found_next     = found_reg;
        phase_next     = phase_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        cmd.kind       = CK_HOLD;
        cmd.tgt        = '0;
        cmd.len        = len_reg;
        cmd.phase      = phase_reg;
        cmd.val        = req_word;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next.status = ST_OK;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    op_next         = action_t'(req.action);
                    val_next        = req_word;
                    cnt_next        = len_reg;
                    step_next       = '0;
                    acc_next        = '0;
                    found_next      = 1'b0;
                    phase_next      = 1'b0;
                    case (action_t'(req.action))
                        ACT_APPEND:
                        begin
                            if (len_ext >= 32'(DEPTH))
                                out_next.status = ST_FULL;
                            else
                            begin
                                cmd.kind = CK_WRITE;
                                cmd.tgt  = len_reg;
                                len_next = len_reg + len_t'(1);
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (len_ext >= 32'(DEPTH))
                                out_next.status = ST_FULL;
                            else if (pos_ext == 32'd0 || pos_ext > len_ext + 32'd1)
                                out_next.status = ST_BAD_POS;
                            else
                            begin
                                cmd.kind = CK_INSERT;
                                cmd.tgt  = LEN_W'(pos_ext - 32'd1);
                                len_next = len_reg + len_t'(1);
                            end
                        end
                        ACT_POP:
                        begin
                            if (pos_ext >= len_ext)
                                out_next.status = ST_BAD_POS;
                            else
                            begin
                                cmd.kind = CK_POP;
                                cmd.tgt  = LEN_W'(pos_ext);
                                len_next = len_reg - len_t'(1);
                            end
                        end
                        ACT_CLEAR:
                            len_next = '0;
                        ACT_REMOVE, ACT_FIND:
                        begin
                            if (len_reg == '0)
                                out_next.status = ST_NOT_FOUND;
                            else
                            begin
                                out_valid_next = out_valid_reg && !rsp_ready;
                                state_next     = S_RUN;
                            end
                        end
                        ACT_COUNT, ACT_REVERSE, ACT_SORT, ACT_DUMP:
                        begin
                            if (len_reg != '0)
                            begin
                                out_valid_next = out_valid_reg && !rsp_ready;
                                state_next     = S_RUN;
                            end
                            else if (action_t'(req.action) == ACT_DUMP)
                                out_valid_next = out_valid_reg && !rsp_ready;
                        end
                        default:
                            out_next.status = ST_OK;
                    endcase
                    // Length after the action, unless overwritten below
                    out_next.data = 32'(len_next);
                end
            end
            S_RUN:
            begin
                if (step_ok)
                begin
                    cnt_next  = cnt_reg - len_t'(1);
                    step_next = step_reg + len_t'(1);
                    case (op_reg)
                        ACT_REMOVE:
                        begin
                            if (match)
                            begin
                                cmd.kind   = CK_POP;
                                cmd.tgt    = '0;
                                len_next   = len_reg - len_t'(1);
                                found_next = 1'b1;
                            end
                            else
                            begin
                                cmd.kind = CK_ROT;
                                cmd.tgt  = len_reg;
                            end
                        end
                        ACT_COUNT:
                        begin
                            cmd.kind = CK_ROT;
                            cmd.tgt  = len_reg;
                            if (match)
                                acc_next = acc_reg + len_t'(1);
                        end
                        ACT_FIND:
                        begin
                            cmd.kind = CK_ROT;
                            cmd.tgt  = len_reg;
                            if (match && !found_reg)
                            begin
                                found_next = 1'b1;
                                fidx_next  = step_reg;
                            end
                        end
                        ACT_REVERSE:
                        begin
                            cmd.kind = CK_ROT;
                            cmd.tgt  = cnt_reg;
                        end
                        ACT_SORT:
                        begin
                            cmd.kind   = CK_SORT;
                            phase_next = !phase_reg;
                        end
                        ACT_DUMP:
                        begin
                            cmd.kind        = CK_ROT;
                            cmd.tgt         = len_reg;
                            out_valid_next  = 1'b1;
                            out_next.status = ST_OK;
                            out_next.data   = word_to_data(head);
                            out_next.last   = (cnt_reg == len_t'(1));
                        end
                        default:
                            cmd.kind = CK_HOLD;
                    endcase
                    // Final step: return to idle and, except for dump, issue the single result
                    if (cnt_reg == len_t'(1))
                    begin
                        state_next = S_IDLE;
                        if (op_reg != ACT_DUMP)
                        begin
                            out_valid_next  = 1'b1;
                            out_next.last   = 1'b1;
                            out_next.status = ST_OK;
                            out_next.data   = 32'(len_next);
                            case (op_reg)
                                ACT_REMOVE:
                                    if (!found_next)
                                        out_next.status = ST_NOT_FOUND;
                                ACT_COUNT:
                                    out_next.data = 32'(acc_next);
                                ACT_FIND:
                                begin
                                    if (found_next)
                                        out_next.data = 32'(fidx_next);
                                    else
                                        out_next.status = ST_NOT_FOUND;
                                end
                                default:
                                    out_next.data = 32'(len_next);
                            endcase
                        end
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        step_reg  <= step_next;
        acc_reg   <= acc_next;
        fidx_reg  <= fidx_next;
        found_reg <= found_next;
        phase_reg <= phase_next;
        op_reg    <= op_next;
        val_reg   <= val_next;
        out_reg   <= out_next;
    end

    `ASSERT_ALWAYS(a_len_bound, 32'(len_reg) <= 32'(DEPTH), "list length beyond depth")
    `ASSERT_IMPL(a_run_cnt, state_reg == S_RUN, cnt_reg != '0 && cnt_reg <= len_reg + step_reg,
        "walk counter out of range")
    `ASSERT_NEXT(a_no_drop, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp),
        "pending result overwritten")
    `ASSERT_IMPL(a_ready_idle, req_ready, state_reg == S_IDLE && slot_free,
        "request taken while busy")

endmodule
